// ===== rtl/core/olb_pkg.sv =====
// Shared constants, codes and types of the ordered list buffer.
package olb_pkg;

	localparam int DEPTH     = 256;
	localparam int WORD_W    = 32;
	localparam int POS_W     = 16;
	localparam int OUT_CNT_W = 9;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	// signed compare width: covers the position and the count with a sign bit
	localparam int CMP_W     = POS_W + 1;
	// read tree: leaves per group, and group count
	localparam int GRP       = 16;
	localparam int NGRP      = (DEPTH + GRP - 1) / GRP;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_INSERT = 2'd2,
		REQ_READ   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [IDX_W-1:0]  pos;
		logic [WORD_W-1:0] wdata;
		logic [IDX_W-1:0]  rd_idx;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/olb_if.sv =====
// Handshake channels of the ordered list buffer: request and response.
interface olb_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic signed [15:0] position;
	logic signed [31:0] value_in;

	modport source (output valid, output req_type, output position, output value_in,
		input ready);
	modport sink (input valid, input req_type, input position, input value_in,
		output ready);
endinterface

interface olb_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] read_value;
	logic [8:0]         entry_count;
	logic [1:0]         status;

	modport source (output valid, output read_value, output entry_count, output status,
		input ready);
	modport sink (input valid, input read_value, input entry_count, input status,
		output ready);
endinterface

// ===== rtl/core/olb_cell.sv =====
// One storage cell of the list chain: holds a word, shifts with its neighbors.
module olb_cell (
	input  logic                             clk,
	input  logic [olb_pkg::IDX_W-1:0]        cell_idx,
	input  olb_pkg::cell_ctrl_t              ctrl,
	input  logic [olb_pkg::WORD_W-1:0]       left_word,
	input  logic [olb_pkg::WORD_W-1:0]       right_word,
	output logic [olb_pkg::WORD_W-1:0]       word,
	output logic [olb_pkg::WORD_W-1:0]       masked
);

	logic [olb_pkg::WORD_W-1:0] word_q;

	// insert: above the slot take the left word, at the slot take the new word
	// remove: at and above the slot take the right word
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (cell_idx > ctrl.pos) begin
				word_q <= left_word;
			end else if (cell_idx == ctrl.pos) begin
				word_q <= ctrl.wdata;
			end
		end else if (ctrl.rem) begin
			if (cell_idx >= ctrl.pos) begin
				word_q <= right_word;
			end
		end
	end

	assign word   = word_q;
	// offer the word to the read tree only when selected
	assign masked = (cell_idx == ctrl.rd_idx) ? word_q : '0;

endmodule

// ===== rtl/core/olb_read_tree.sv =====
// Registered OR tree that gathers the selected cell word.
module olb_read_tree (
	input  logic                       clk,
	input  logic                       en,
	input  logic [olb_pkg::WORD_W-1:0] leaf [olb_pkg::DEPTH],
	output logic [olb_pkg::WORD_W-1:0] result
);

	logic [olb_pkg::WORD_W-1:0] grp_d [olb_pkg::NGRP];
	logic [olb_pkg::WORD_W-1:0] grp_q [olb_pkg::NGRP];

	// fold each group of leaves
	always_comb begin
		for (int g = 0; g < olb_pkg::NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < olb_pkg::GRP; k++) begin
				if (g * olb_pkg::GRP + k < olb_pkg::DEPTH) begin
					grp_d[g] = grp_d[g] | leaf[g * olb_pkg::GRP + k];
				end
			end
		end
	end

	// hold the group results
	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < olb_pkg::NGRP; g++) begin
				grp_q[g] <= grp_d[g];
			end
		end
	end

	// fold the groups
	always_comb begin
		result = '0;
		for (int g = 0; g < olb_pkg::NGRP; g++) begin
			result = result | grp_q[g];
		end
	end

endmodule

// ===== rtl/core/ordered_list_buffer_core.sv =====
// Top level of the ordered list buffer: request decode, cell chain, read path.
//
// Usage:
//   req carries one request beat: req_type (append, remove, insert, read),
//   position and value_in. rsp returns one beat per request: read_value,
//   entry_count after the request, and status (ok, full, out of range, empty).
//   The words live in a chain of DEPTH cells; an insert or remove shifts the
//   affected cells in the cycle the request is taken, and an insert writes
//   the new word at its slot. The response passes decode and cell update,
//   the group OR of the read tree and the final OR into the output register.
//   Only one request is in the cells and tree stages at a time, so a new
//   request waits until the last one has moved on to the output register.
//   A new request is taken while a finished response still waits in the
//   output register. If the receiver stalls, the response holds and the
//   following request waits in the tree stages, so req.ready stays low.
//   Reset clears the count to zero and empties the pipeline; cell contents
//   are not cleared and are never read before written.
module ordered_list_buffer_core (
	input  logic      clk,
	input  logic      arst_n,
	olb_req_if.sink   req,
	olb_rsp_if.source rsp
);

	logic [olb_pkg::CNT_W-1:0]  count_q;
	logic [olb_pkg::CNT_W-1:0]  count_d;
	olb_pkg::status_t           st_d;
	logic                       rd_d;
	logic                       ins_d;
	logic                       rem_d;
	logic [olb_pkg::IDX_W-1:0]  pos_d;
	logic [olb_pkg::IDX_W-1:0]  rd_idx_d;
	logic signed [olb_pkg::CMP_W-1:0] posx;
	logic signed [olb_pkg::CMP_W-1:0] cntx;
	logic                       full;
	logic                       acc;

	logic                       v_s1;
	logic                       v_s2;
	logic                       rd_s1;
	logic                       rd_s2;
	olb_pkg::status_t           st_s1;
	olb_pkg::status_t           st_s2;
	logic [olb_pkg::CNT_W-1:0]  cnt_s1;
	logic [olb_pkg::CNT_W-1:0]  cnt_s2;
	logic [olb_pkg::IDX_W-1:0]  rd_idx_s1;
	logic                       adv2;

	logic                       out_valid_q;
	logic [olb_pkg::WORD_W-1:0] out_value_q;
	logic [olb_pkg::CNT_W-1:0]  out_cnt_q;
	olb_pkg::status_t           out_st_q;

	olb_pkg::cell_ctrl_t        ctrl;
	logic [olb_pkg::WORD_W-1:0] word   [olb_pkg::DEPTH];
	logic [olb_pkg::WORD_W-1:0] masked [olb_pkg::DEPTH];
	logic [olb_pkg::WORD_W-1:0] tree_result;

	// take a request only when both tree stages are empty
	assign req.ready = !v_s1 && !v_s2;
	assign acc       = req.valid && req.ready;

	assign posx = olb_pkg::CMP_W'(req.position);
	assign cntx = $signed({{(olb_pkg::CMP_W - olb_pkg::CNT_W){1'b0}}, count_q});
	assign full = (count_q == olb_pkg::CNT_W'(olb_pkg::DEPTH));

	// decode the request against the current count
	always_comb begin
		count_d  = count_q;
		st_d     = olb_pkg::ST_OK;
		rd_d     = 1'b0;
		ins_d    = 1'b0;
		rem_d    = 1'b0;
		pos_d    = req.position[olb_pkg::IDX_W-1:0];
		rd_idx_d = req.position[olb_pkg::IDX_W-1:0];
		unique case (olb_pkg::req_kind_t'(req.req_type))
			olb_pkg::REQ_APPEND: begin
				if (full) begin
					st_d = olb_pkg::ST_FULL;
				end else begin
					ins_d   = 1'b1;
					pos_d   = count_q[olb_pkg::IDX_W-1:0];
					count_d = olb_pkg::CNT_W'(count_q + olb_pkg::CNT_W'(1));
				end
			end
			olb_pkg::REQ_REMOVE: begin
				if (posx < 0 || posx >= cntx) begin
					st_d = olb_pkg::ST_RANGE;
				end else begin
					rem_d   = 1'b1;
					count_d = olb_pkg::CNT_W'(count_q - olb_pkg::CNT_W'(1));
				end
			end
			olb_pkg::REQ_INSERT: begin
				if (full) begin
					st_d = olb_pkg::ST_FULL;
				end else if (posx < 0 || posx > cntx) begin
					st_d = olb_pkg::ST_RANGE;
				end else begin
					ins_d   = 1'b1;
					count_d = olb_pkg::CNT_W'(count_q + olb_pkg::CNT_W'(1));
				end
			end
			olb_pkg::REQ_READ: begin
				if (count_q == '0) begin
					st_d = olb_pkg::ST_EMPTY;
				end else begin
					rd_d = 1'b1;
					if (posx < 0) begin
						rd_idx_d = '0;
					end else if (posx >= cntx) begin
						rd_idx_d = olb_pkg::IDX_W'(count_q - olb_pkg::CNT_W'(1));
					end
				end
			end
			default: begin
				st_d = olb_pkg::ST_OK;
			end
		endcase
	end

	// drive the cell chain; updates land only on an accepted beat
	always_comb begin
		ctrl.ins    = acc && ins_d;
		ctrl.rem    = acc && rem_d;
		ctrl.pos    = pos_d;
		ctrl.wdata  = req.value_in;
		ctrl.rd_idx = rd_idx_s1;
	end

	for (genvar i = 0; i < olb_pkg::DEPTH; i++) begin : g_cell
		logic [olb_pkg::WORD_W-1:0] left_w;
		logic [olb_pkg::WORD_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = word[i-1];
		end
		if (i == olb_pkg::DEPTH - 1) begin : g_last
			assign right_w = word[i];
		end else begin : g_mid_r
			assign right_w = word[i+1];
		end
		olb_cell u_cell (
			.clk        (clk),
			.cell_idx   (olb_pkg::IDX_W'(i)),
			.ctrl       (ctrl),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (word[i]),
			.masked     (masked[i])
		);
	end

	olb_read_tree u_tree (
		.clk    (clk),
		.en     (v_s1),
		.leaf   (masked),
		.result (tree_result)
	);

	// advance the last stage when the output register is free or being taken
	assign adv2 = v_s2 && (!out_valid_q || rsp.ready);

	// count and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= count_d;
			end
			v_s1 <= acc;
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1     <= rd_d;
			st_s1     <= st_d;
			cnt_s1    <= count_d;
			rd_idx_s1 <= rd_idx_d;
		end
		if (v_s1) begin
			rd_s2  <= rd_s1;
			st_s2  <= st_s1;
			cnt_s2 <= cnt_s1;
		end
		if (adv2) begin
			out_value_q <= rd_s2 ? tree_result : '0;
			out_cnt_q   <= cnt_s2;
			out_st_q    <= st_s2;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = $signed(out_value_q);
	assign rsp.entry_count = olb_pkg::OUT_CNT_W'(out_cnt_q);
	assign rsp.status      = out_st_q;

endmodule
